/* rtl/core/trbq_pkg.sv */
// shared constants and command codes for the timed ring bucket queue
`timescale 1ns / 1ps
`default_nettype none
package trbq_pkg;
  localparam int SLOTS_DEF    = 256;
  localparam int TASKS_DEF    = 256;
  localparam int ID_W         = 8;
  localparam int TIME_W       = 64;
  localparam longint unsigned SLOT_NS = 64'd5000000;
  localparam int SLOT_NS_BITS = $clog2(SLOT_NS + 1);

  // slot length split as an odd factor times a power of two
  localparam int SLOT_SHIFT   = 6;
  localparam longint unsigned SLOT_ODD = 64'd78125;
  localparam int SLOT_ODD_W   = $clog2(SLOT_ODD);

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;
endpackage
`default_nettype wire

/* rtl/core/trbq_ram.sv */
// simple dual port synchronous ram, registered read
`timescale 1ns / 1ps
`default_nettype none
module trbq_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [DW-1:0]                                wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [DW-1:0]                                rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/trbq_div.sv */
// divider by the slot length: shift out the power of two, then reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none
module trbq_div #(
  parameter int RW = 31,
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [RW-1:0] dividend,
  output logic               busy,
  output logic      [QW-1:0] quot
);
  localparam int YW  = RW - trbq_pkg::SLOT_SHIFT;
  localparam int SH  = YW + trbq_pkg::SLOT_ODD_W;
  localparam int MW  = YW + 1;
  localparam int PRW = YW + MW;
  // rounded-up reciprocal, exact for every dividend below 2^RW
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + trbq_pkg::SLOT_ODD - 64'd1) / trbq_pkg::SLOT_ODD;

  logic [YW-1:0]  y_r;
  logic           pend_r;
  logic [QW-1:0]  q_r;
  logic [PRW-1:0] prod;

  assign prod = PRW'(y_r) * PRW'(RECIP[MW-1:0]);
  assign busy = pend_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y_r <= dividend[RW-1:trbq_pkg::SLOT_SHIFT];
    end
    if (pend_r) begin
      q_r <= QW'(prod >> SH);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/timed_ring_bucket_queue.sv */
// top level of the timed ring bucket queue (timing wheel calendar queue)
`timescale 1ns / 1ps
`default_nettype none
// usage
//   input channel in_*: one request per handshake, in_command selects enqueue
//   of in_task_id at in_due_time, or dequeue of the head of the first occupied bucket
//   result channel out_*: one result per dequeue, none per enqueue
//   enqueue runs from acceptance to the next request through base update,
//   a reciprocal-multiply division of the due offset by the slot length,
//   then the bucket read and write-back
//   dequeue reads the occupancy bitmap one word at a time (16 bits wide, 8 when
//   SLOTS < 16), starting at the base slot's word and wrapping back to it,
//   then head/tail and link/due reads follow; a hit in the base slot's word
//   gives the shortest path from acceptance to out_valid
//   one request is worked on at a time; the result sits in an output
//   register, so enqueue requests keep flowing while the receiver stalls
//   a dequeue finishing under a stall waits until the output register frees
//   after reset a clearing pass zeroes the bitmap memory;
//   in_ready stays low during it
//   task and bucket list memories are not cleared and hold junk until written
module timed_ring_bucket_queue #(
  parameter int SLOTS = trbq_pkg::SLOTS_DEF,
  parameter int TASKS = trbq_pkg::TASKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_command,
  input  wire logic [trbq_pkg::ID_W-1:0]   in_task_id,
  input  wire logic [trbq_pkg::TIME_W-1:0] in_due_time,
  input  wire logic [trbq_pkg::TIME_W-1:0] in_now_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic      [trbq_pkg::ID_W-1:0]   out_task,
  output logic      [trbq_pkg::TIME_W-1:0] out_due_time
);
  localparam int TW   = trbq_pkg::TIME_W;
  localparam int IDW  = trbq_pkg::ID_W;
  localparam int SW   = $clog2(SLOTS);
  localparam int TIW  = $clog2(TASKS);
  localparam int W    = (SLOTS < 16) ? 8 : 16;          // bitmap word width
  localparam int BW   = $clog2(W);
  localparam int NW   = (SLOTS + W - 1) / W;            // bitmap words
  localparam int CW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int NCW  = $clog2(NW + 2);
  localparam longint unsigned LIMIT = 64'(SLOTS) * trbq_pkg::SLOT_NS;
  localparam int RW   = $clog2(LIMIT);
  localparam int PW   = SW + trbq_pkg::SLOT_NS_BITS;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_E_PREP, ST_E_DIV, ST_E_RD, ST_E_WR,
    ST_D_RQ, ST_D_CHK, ST_D_HT, ST_D_TK, ST_D_OUT
  } state_t;

  state_t          st_r;
  logic [CW-1:0]   clr_r;
  logic [TIW-1:0]  task_r;
  logic [TW-1:0]   due_r;
  logic [TW-1:0]   now_r;
  logic [TW-1:0]   base_time_r;
  logic [SW-1:0]   base_slot_r;
  logic            lt_r;
  logic            cap_r;
  logic [SW-1:0]   slot_r;
  logic [CW-1:0]   chunk_r;
  logic [NCW-1:0]  n_r;
  logic [W-1:0]    occ_word_r;
  logic            last_r;
  logic [PW-1:0]   prod_r;
  logic            res_found_r;
  logic [TIW-1:0]  res_task_r;
  logic [TW-1:0]   res_due_r;
  logic            out_valid_r;
  logic            out_found_r;
  logic [IDW-1:0]  out_task_r;
  logic [TW-1:0]   out_due_r;

  // memory ports
  logic            occ_we;
  logic [CW-1:0]   occ_waddr, occ_raddr;
  logic [W-1:0]    occ_wdata, occ_rd;
  logic            head_we;
  logic [SW-1:0]   head_waddr, bkt_raddr;
  logic [TIW-1:0]  head_wdata, head_rd, tail_rd;
  logic            tail_we;
  logic            link_we;
  logic [TIW-1:0]  link_rd, due_raddr;
  logic            due_we;
  logic [TW-1:0]   due_rd;

  // divider
  logic            div_start, div_busy;
  logic [SW-1:0]   div_q;

  // combinational helpers
  logic [20:0]     tmod;
  logic [TIW-1:0]  in_task_idx;
  logic [TW-1:0]   base_eff;
  logic [TW-1:0]   diff;
  logic [SW-1:0]   off;
  logic [SW:0]     slot_sum;
  logic [SW-1:0]   enq_slot;
  logic [BW-1:0]   base_bit;
  logic [W-1:0]    mask, masked;
  logic            any_hit;
  logic [BW-1:0]   pe;
  logic [CW+BW-1:0] hit_cat;
  logic [SW-1:0]   hit_slot;
  logic [SW:0]     adv_slots;
  logic [TIW+IDW-1:0] task_ext;
  logic            acc;
  logic            out_free;

  function automatic logic [CW-1:0] word_of(input logic [SW-1:0] s);
    logic [SW+CW-1:0] t;
    t = (SW + CW)'(s) >> BW;
    return t[CW-1:0];
  endfunction

  assign in_ready  = (st_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_task     = out_task_r;
  assign out_due_time = out_due_r;

  // task id modulo TASKS, restoring steps on a narrow value
  always_comb begin
    tmod = 21'(in_task_id);
    for (int k = 7; k >= 0; k--) begin
      if (tmod >= (21'(TASKS) << k)) begin
        tmod = tmod - (21'(TASKS) << k);
      end
    end
    in_task_idx = TIW'(tmod);
  end

  // enqueue: base time and offset from it
  assign base_eff  = (base_time_r == '0) ? now_r : base_time_r;
  assign diff      = due_r - base_eff;
  assign div_start = (st_r == ST_E_PREP);

  always_comb begin
    if (lt_r) begin
      off = '0;
    end else if (cap_r) begin
      off = SW'(SLOTS - 1);
    end else begin
      off = div_q;
    end
    slot_sum = {1'b0, base_slot_r} + {1'b0, off};
    if (slot_sum >= (SW + 1)'(SLOTS)) begin
      slot_sum = slot_sum - (SW + 1)'(SLOTS);
    end
    enq_slot = slot_sum[SW-1:0];
  end

  // dequeue: masked bitmap word and lowest set bit
  assign base_bit = base_slot_r[BW-1:0];
  always_comb begin
    for (int j = 0; j < W; j++) begin
      if (n_r == '0) begin
        mask[j] = (BW'(j) >= base_bit);
      end else if (n_r == NCW'(NW)) begin
        mask[j] = (BW'(j) < base_bit);
      end else begin
        mask[j] = 1'b1;
      end
    end
    masked  = occ_rd & mask;
    any_hit = (masked != '0);
    pe      = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (masked[j]) begin
        pe = BW'(j);
      end
    end
    hit_cat  = {chunk_r, pe};
    hit_slot = SW'(hit_cat);
  end

  // slots the base moves forward by
  always_comb begin
    if (slot_r >= base_slot_r) begin
      adv_slots = {1'b0, slot_r} - {1'b0, base_slot_r};
    end else begin
      adv_slots = {1'b0, slot_r} + (SW + 1)'(SLOTS) - {1'b0, base_slot_r};
    end
  end

  assign task_ext = {{IDW{1'b0}}, res_task_r};

  // memory port steering
  always_comb begin
    occ_we     = 1'b0;
    occ_waddr  = word_of(slot_r);
    occ_wdata  = occ_rd;
    occ_raddr  = chunk_r;
    head_we    = 1'b0;
    head_waddr = slot_r;
    head_wdata = task_r;
    tail_we    = 1'b0;
    link_we    = 1'b0;
    due_we     = 1'b0;
    bkt_raddr  = hit_slot;
    due_raddr  = head_rd;
    case (st_r)
      ST_CLR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_r;
        occ_wdata = '0;
      end
      ST_E_RD: begin
        occ_raddr = word_of(enq_slot);
        bkt_raddr = enq_slot;
      end
      ST_E_WR: begin
        occ_we    = 1'b1;
        occ_wdata = occ_rd | (W'(1) << slot_r[BW-1:0]);
        due_we    = 1'b1;
        if (occ_rd[slot_r[BW-1:0]]) begin
          link_we = 1'b1;
        end else begin
          head_we = 1'b1;
        end
        tail_we = 1'b1;
      end
      ST_D_HT: begin
        if (head_rd == tail_rd) begin
          occ_we    = 1'b1;
          occ_waddr = chunk_r;
          occ_wdata = occ_word_r & ~(W'(1) << slot_r[BW-1:0]);
        end
      end
      ST_D_TK: begin
        if (!last_r) begin
          head_we    = 1'b1;
          head_wdata = link_rd;
        end
      end
      default: begin
      end
    endcase
  end

  trbq_ram #(.DW(W), .DEPTH(NW)) u_occ (
    .clk, .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rd)
  );
  trbq_ram #(.DW(TIW), .DEPTH(SLOTS)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(bkt_raddr), .rdata(head_rd)
  );
  trbq_ram #(.DW(TIW), .DEPTH(SLOTS)) u_tail (
    .clk, .we(tail_we), .waddr(slot_r), .wdata(task_r),
    .raddr(bkt_raddr), .rdata(tail_rd)
  );
  trbq_ram #(.DW(TIW), .DEPTH(TASKS)) u_link (
    .clk, .we(link_we), .waddr(tail_rd), .wdata(task_r),
    .raddr(due_raddr), .rdata(link_rd)
  );
  trbq_ram #(.DW(TW), .DEPTH(TASKS)) u_due (
    .clk, .we(due_we), .waddr(task_r), .wdata(due_r),
    .raddr(due_raddr), .rdata(due_rd)
  );

  trbq_div #(.RW(RW), .QW(SW)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(diff[RW-1:0]),
    .busy(div_busy), .quot(div_q)
  );

  // sequencer, base registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_r       <= '0;
      base_slot_r <= '0;
      base_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loaded in ST_D_OUT takes the place of the one leaving
      if (out_valid_r && out_ready && (st_r != ST_D_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(NW - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            task_r  <= in_task_idx;
            due_r   <= in_due_time;
            now_r   <= in_now_time;
            chunk_r <= word_of(base_slot_r);
            n_r     <= '0;
            st_r    <= (in_command == trbq_pkg::CMD_DEQ) ? ST_D_RQ : ST_E_PREP;
          end
        end
        ST_E_PREP: begin
          base_time_r <= base_eff;
          lt_r        <= (due_r < base_eff);
          cap_r       <= (diff >= TW'(LIMIT));
          st_r        <= ST_E_DIV;
        end
        ST_E_DIV: begin
          if (!div_busy) begin
            st_r <= ST_E_RD;
          end
        end
        ST_E_RD: begin
          slot_r <= enq_slot;
          st_r   <= ST_E_WR;
        end
        ST_E_WR: begin
          st_r <= ST_IDLE;
        end
        ST_D_RQ: begin
          st_r <= ST_D_CHK;
        end
        ST_D_CHK: begin
          if (any_hit) begin
            slot_r     <= hit_slot;
            occ_word_r <= occ_rd;
            st_r       <= ST_D_HT;
          end else if (n_r == NCW'(NW)) begin
            base_time_r <= '0;
            res_found_r <= 1'b0;
            res_task_r  <= '0;
            res_due_r   <= '0;
            st_r        <= ST_D_OUT;
          end else begin
            n_r     <= n_r + 1'b1;
            chunk_r <= (chunk_r == CW'(NW - 1)) ? '0 : chunk_r + 1'b1;
            st_r    <= ST_D_RQ;
          end
        end
        ST_D_HT: begin
          task_r <= head_rd;
          last_r <= (head_rd == tail_rd);
          prod_r <= PW'(adv_slots[SW-1:0]) *
                    PW'(trbq_pkg::SLOT_NS[trbq_pkg::SLOT_NS_BITS-1:0]);
          st_r   <= ST_D_TK;
        end
        ST_D_TK: begin
          base_slot_r <= slot_r;
          base_time_r <= base_time_r + TW'(prod_r);
          res_found_r <= 1'b1;
          res_task_r  <= task_r;
          res_due_r   <= due_rd;
          st_r        <= ST_D_OUT;
        end
        ST_D_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_task_r  <= task_ext[IDW-1:0];
            out_due_r   <= res_due_r;
            st_r        <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/tb_timed_ring_bucket_queue.sv */
// self-checking testbench for the timed ring bucket queue
`timescale 1ns / 1ps

module tb_timed_ring_bucket_queue;

  // one dequeue result as the block should present it
  typedef struct {
    bit          found;
    logic [7:0]  id;
    logic [63:0] due;
  } wheel_result_t;

  // shadow of the timing wheel: predicts every dequeue and holds the results still owed
  class wheel_scoreboard;
    logic [63:0]   due_of  [256];
    logic [7:0]    link_of [256];
    logic [7:0]    head_of [256];
    logic [7:0]    tail_of [256];
    bit            occ     [256];
    logic [7:0]    base_slot;
    logic [63:0]   base_time;
    wheel_result_t owed[$];
    int            errors;

    function new();
      foreach (occ[i]) begin
        occ[i] = 0;
        due_of[i] = '0;
        link_of[i] = '0;
        head_of[i] = '0;
        tail_of[i] = '0;
      end
      base_slot = '0;
      base_time = '0;
      errors = 0;
    endfunction

    // files an accepted request; returns the id a dequeue pops, else -1
    function int note_request(bit cmd, logic [7:0] id, logic [63:0] due, logic [63:0] now);
      logic [63:0]   off;
      logic [7:0]    slot;
      logic [7:0]    tsk;
      logic [7:0]    adv;
      bit            hit;
      wheel_result_t r;
      if (cmd == trbq_pkg::CMD_ENQ) begin
        if (base_time == 0) base_time = now;
        // a due time before the base lands in the base bucket
        off = (due < base_time) ? 64'd0 : (due - base_time) / trbq_pkg::SLOT_NS;
        if (off > 64'd255) off = 64'd255;
        slot = base_slot + off[7:0];
        due_of[id] = due;
        if (occ[slot]) begin
          link_of[tail_of[slot]] = id;
          tail_of[slot] = id;
        end else begin
          head_of[slot] = id;
          tail_of[slot] = id;
          occ[slot] = 1;
        end
        return -1;
      end
      hit = 0;
      slot = base_slot;
      for (int k = 0; k < 256; k++) begin
        slot = base_slot + k[7:0];
        if (occ[slot]) begin
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        base_time = '0;
        r = '{0, 8'd0, 64'd0};
        owed.push_back(r);
        return -1;
      end
      tsk = head_of[slot];
      if (tsk == tail_of[slot]) occ[slot] = 0;
      else head_of[slot] = link_of[tsk];
      adv = slot - base_slot;
      base_slot = slot;
      base_time = base_time + trbq_pkg::SLOT_NS * 64'(adv);
      r = '{1, tsk, due_of[tsk]};
      owed.push_back(r);
      return tsk;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(bit found, logic [7:0] id, logic [63:0] due);
      wheel_result_t w;
      if (owed.size() == 0) begin
        report("result with nothing owed");
        return;
      end
      w = owed.pop_front();
      if (found !== w.found) report($sformatf("found %0b, want %0b", found, w.found));
      if (id !== w.id) report($sformatf("task %0d, want %0d", id, w.id));
      if (due !== w.due) report($sformatf("due %0h, want %0h", due, w.due));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_command = trbq_pkg::CMD_ENQ;
  logic [7:0]  in_task_id = '0;
  logic [63:0] in_due_time = '0;
  logic [63:0] in_now_time = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_found;
  logic [7:0]  out_task;
  logic [63:0] out_due_time;

  wheel_scoreboard sb = new();

  // generator's view of which ids sit in the wheel, so none is filed twice
  bit          queued[256];
  int          queued_count = 0;
  logic [63:0] clock_now = 64'd1000;
  int          results_seen = 0;
  bit          calm_sender = 0;
  bit          calm_receiver = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  timed_ring_bucket_queue uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_task_id(in_task_id), .in_due_time(in_due_time), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_task(out_task), .out_due_time(out_due_time)
  );

  // drive one request after a gap, hold it until accepted, then predict it
  task send_request(bit cmd, logic [7:0] id, logic [63:0] due, logic [63:0] now);
    int gap;
    int popped;
    gap = calm_sender ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1;
    in_command  <= cmd;
    in_task_id  <= id;
    in_due_time <= due;
    in_now_time <= now;
    do @(posedge clk); while (!in_ready);
    popped = sb.note_request(cmd, id, due, now);
    if (cmd == trbq_pkg::CMD_ENQ) begin
      queued[id] = 1;
      queued_count++;
    end else if (popped >= 0) begin
      queued[popped] = 0;
      queued_count--;
    end
  endtask

  task enqueue(logic [7:0] id, logic [63:0] due, logic [63:0] now);
    send_request(trbq_pkg::CMD_ENQ, id, due, now);
  endtask

  task dequeue();
    send_request(trbq_pkg::CMD_DEQ, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                 {$urandom, $urandom});
  endtask

  // random request, mostly well-formed: due times near the clock, ids not yet queued
  task random_request();
    int          pick;
    logic [7:0]  id;
    logic [63:0] due;
    logic [63:0] now;
    clock_now = clock_now + $urandom_range(0, 3 * 5000000);
    if (queued_count == 256 || (queued_count > 0 && $urandom_range(0, 99) < 45)) begin
      dequeue();
      return;
    end
    do id = 8'($urandom_range(0, 255)); while (queued[id]);
    pick = $urandom_range(0, 99);
    if (pick < 60)      due = clock_now + $urandom_range(0, 40 * 5000000);
    else if (pick < 75) due = clock_now + 64'($urandom_range(0, 400)) * trbq_pkg::SLOT_NS;
    else if (pick < 85) due = clock_now - $urandom_range(0, 20 * 5000000);
    else if (pick < 95) due = {$urandom, $urandom};
    else                due = ($urandom_range(0, 1) != 0) ? '1 : '0;
    // the clock only matters while the base is clear; randomise it sometimes
    now = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : clock_now;
    enqueue(id, due, now);
  endtask

  // sender
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: empty dequeue, zero clock, extremes, past and far due times
    dequeue();
    enqueue(8'd0, 64'd0, 64'd0);
    dequeue();
    dequeue();
    enqueue(8'd255, '1, '1);
    enqueue(8'd1, 64'd0, 64'd123);
    enqueue(8'd2, '1, 64'd0);
    dequeue();
    dequeue();
    dequeue();
    dequeue();
    enqueue(8'd10, 64'd1000 + 3 * trbq_pkg::SLOT_NS, 64'd1000);
    enqueue(8'd11, 64'd1000 + 3 * trbq_pkg::SLOT_NS + 1, 64'd5);
    enqueue(8'd12, 64'd1000 + 300 * trbq_pkg::SLOT_NS, 64'd5);
    enqueue(8'd13, 64'd1000 + 10 * trbq_pkg::SLOT_NS, 64'd5);
    dequeue();
    // base now sits at slot 3; the far task was capped to slot 255
    enqueue(8'd14, 64'd0, 64'd5);
    enqueue(8'd15, 64'd1000 + 254 * trbq_pkg::SLOT_NS, 64'd5);
    repeat (5) dequeue();
    dequeue();
    for (int n = 0; n < 1850; n++) begin
      if (n % 60 == 0) calm_sender = ($urandom_range(0, 3) == 0);
      if (n == 900) begin
        // pause until the wheel has answered everything owed
        @(negedge clk);
        in_valid <= 0;
        wait (sb.owed.size() == 0);
        repeat (50) @(posedge clk);
      end
      random_request();
    end
    @(negedge clk);
    in_valid <= 0;
    wait (sb.owed.size() == 0);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, calm stretches, and one long hold so input backs up
  initial begin
    int gap;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (results_seen % 50 == 0) calm_receiver = ($urandom_range(0, 3) == 0);
      gap = calm_receiver ? 0 : $urandom_range(0, 12);
      if (!held && results_seen >= 60) begin
        held = 1;
        gap = 400;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_found, out_task, out_due_time);
      results_seen <= results_seen + 1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule
